>>> hw/rtl/gn2d_pkg.sv
// Shared constants, operation and gradient codes, and the corner gradient
// function for the 2D gradient noise unit.
// No dependencies.
`timescale 1ns / 1ps

package gn2d_pkg;

  // Fixed-point format and table geometry (table size must be a power of two)
  localparam int FRAC_BITS  = 16;
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int HASH_W     = 8;
  localparam int COORD_W    = 32;
  localparam int OUT_W      = 19;
  localparam int FX_ONE     = 1 << FRAC_BITS;
  localparam int FX_HALF    = 1 << (FRAC_BITS - 1);

  // Derived datapath widths
  localparam int FADE_W  = FRAC_BITS + 1;  // fade in [0, 1], unsigned
  localparam int DELTA_W = FRAC_BITS + 2;  // corner offset in [-1, 1), signed
  localparam int GRAD_W  = FRAC_BITS + 3;  // gradient dot product, signed
  localparam int LERP_W  = GRAD_W + 1;     // interpolation values and differences

  // Stream payload widths
  localparam int IN_DATA_W  = IDX_W + HASH_W + 2 * COORD_W;
  localparam int IN_BYTES_W = ((IN_DATA_W + 7) / 8) * 8;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;

  // Operation codes carried in tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Gradient selector codes (low three bits of a corner hash)
  localparam logic [2:0] GRAD_PX_PY = 3'd0;
  localparam logic [2:0] GRAD_NX_PY = 3'd1;
  localparam logic [2:0] GRAD_PX_NY = 3'd2;
  localparam logic [2:0] GRAD_NX_NY = 3'd3;
  localparam logic [2:0] GRAD_PX    = 3'd4;
  localparam logic [2:0] GRAD_NX    = 3'd5;
  localparam logic [2:0] GRAD_PY    = 3'd6;
  localparam logic [2:0] GRAD_NY    = 3'd7;

  // Dot product of the selected gradient with the corner offset
  function automatic logic signed [GRAD_W-1:0] grad_dot(
    input logic [2:0]                sel,
    input logic signed [DELTA_W-1:0] dx,
    input logic signed [DELTA_W-1:0] dy
  );
    logic signed [GRAD_W-1:0] ex;
    logic signed [GRAD_W-1:0] ey;
    logic signed [GRAD_W-1:0] res;
    ex = {{(GRAD_W - DELTA_W){dx[DELTA_W-1]}}, dx};
    ey = {{(GRAD_W - DELTA_W){dy[DELTA_W-1]}}, dy};
    case (sel)
      GRAD_PX_PY: res = ex + ey;
      GRAD_NX_PY: res = ey - ex;
      GRAD_PX_NY: res = ex - ey;
      GRAD_NX_NY: res = -ex - ey;
      GRAD_PX:    res = ex;
      GRAD_NX:    res = -ex;
      GRAD_PY:    res = ey;
      GRAD_NY:    res = -ey;
      default:    res = '0;
    endcase
    return res;
  endfunction

endpackage

>>> hw/rtl/gn2d_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module gn2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads, held while re_i is low
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

>>> hw/rtl/gn2d_fade.sv
// Three-stage pipelined quintic fade 6t^5 - 15t^4 + 10t^3 on a fraction.
// Depends on gn2d_pkg.
`timescale 1ns / 1ps

module gn2d_fade
  import gn2d_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [FRAC_BITS-1:0] t_i,
  output logic [FADE_W-1:0]    fade_o
);

  localparam int F     = FRAC_BITS;
  localparam int LIN_W = F + 5;          // 6t - 15 and k, signed
  localparam int KP_W  = F + 1 + LIN_W;  // t * (6t - 15)
  localparam int FP_W  = F + 2 + LIN_W;  // t3 * k

  localparam logic signed [LIN_W-1:0] LIN_OFS = LIN_W'(15 * FX_ONE);
  localparam logic signed [LIN_W-1:0] K_OFS   = LIN_W'(10 * FX_ONE);
  localparam logic signed [KP_W-1:0]  KP_HALF = KP_W'(FX_HALF);
  localparam logic signed [FP_W-1:0]  FP_HALF = FP_W'(FX_HALF);
  localparam logic signed [FP_W-1:0]  FP_ONE  = FP_W'(FX_ONE);

  // Stage 1: t^2 and k = t(6t - 15) + 10
  logic [2*F:0]             t2_s;
  logic signed [LIN_W-1:0]  lin;
  logic signed [KP_W-1:0]   km_p;
  logic signed [KP_W-1:0]   km_r;
  logic [F-1:0]             t1_q;
  logic [F:0]               t2_q;
  logic signed [LIN_W-1:0]  k1_q;

  always_comb begin
    t2_s = ({1'b0, t_i} * {1'b0, t_i}) + (2*F+1)'(FX_HALF);
    lin  = LIN_W'({t_i, 2'b00}) + LIN_W'({t_i, 1'b0}) - LIN_OFS;
    km_p = $signed({1'b0, t_i}) * lin;
    km_r = (km_p + KP_HALF) >>> F;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q <= t_i;
      t2_q <= t2_s[2*F:F];
      k1_q <= km_r[LIN_W-1:0] + K_OFS;
    end
  end

  // Stage 2: t^3
  logic [2*F+1:0]          t3_s;
  logic [F:0]              t3_q;
  logic signed [LIN_W-1:0] k2_q;

  assign t3_s = ({1'b0, t2_q} * {2'b00, t1_q}) + (2*F+2)'(FX_HALF);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t3_q <= t3_s[2*F:F];
      k2_q <= k1_q;
    end
  end

  // Stage 3: t^3 * k, clamped to [0, 1]
  logic signed [FP_W-1:0] f_p;
  logic signed [FP_W-1:0] f_r;
  logic [FADE_W-1:0]      fade_d;
  logic [FADE_W-1:0]      fade_q;

  always_comb begin
    f_p = $signed({1'b0, t3_q}) * k2_q;
    f_r = (f_p + FP_HALF) >>> F;
    if (f_r < 0) begin
      fade_d = '0;
    end else if (f_r > FP_ONE) begin
      fade_d = FADE_W'(FX_ONE);
    end else begin
      fade_d = f_r[FADE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fade_q <= fade_d;
    end
  end

  assign fade_o = fade_q;

endmodule

>>> hw/rtl/gradient_noise_2d_unit.sv
// Top level of the 2D gradient noise unit: stream ports, permutation table
// copies, fade pipelines, corner gradients and interpolation.
// Depends on gn2d_pkg, gn2d_ram and gn2d_fade.
`timescale 1ns / 1ps

// Evaluates 2D improved Perlin noise at one signed Q15.16 point per clock
// unless the master side stalls. A transaction with tuser = 1 is a point;
// its result appears on the master side in order, and points may be sent
// in every cycle. A transaction with tuser = 0 writes one permutation entry
// and gives no result; all 256 entries must be loaded before the first
// point, and entries may be rewritten between points at any time.
// The six table lookups of a point are served by three copies of the table,
// each with two read ports, which sets the rate at one point per cycle.
// While a result waits on m_axis_tready the whole pipeline holds, so no
// transaction is lost or repeated.
module gradient_noise_2d_unit
  import gn2d_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Slave side
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: table_index[7:0], table_value[15:8], x_coord[47:16], y_coord[79:48]
  input  logic [IN_BYTES_W-1:0]  s_axis_tdata,
  // tuser: op[0]
  input  logic                   s_axis_tuser,
  // Master side
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: noise_value[18:0], zero filled above
  output logic [OUT_BYTES_W-1:0] m_axis_tdata
);

  localparam int F       = FRAC_BITS;
  localparam int X_LSB   = IDX_W + HASH_W;
  localparam int Y_LSB   = X_LSB + COORD_W;
  localparam int LP_W    = FADE_W + 1 + LERP_W;

  localparam logic signed [DELTA_W-1:0] D_ONE  = DELTA_W'(FX_ONE);
  localparam logic signed [LP_W-1:0]    LP_HALF = LP_W'(FX_HALF);
  localparam logic signed [LERP_W-1:0]  SAT_HI = LERP_W'(2 * FX_ONE);
  localparam logic signed [LERP_W-1:0]  SAT_LO = -LERP_W'(2 * FX_ONE);

  // Input field unpacking
  logic [IDX_W-1:0]   in_index;
  logic [HASH_W-1:0]  in_value;
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;

  assign in_index = s_axis_tdata[IDX_W-1:0];
  assign in_value = s_axis_tdata[IDX_W+HASH_W-1:IDX_W];
  assign in_x     = s_axis_tdata[X_LSB+COORD_W-1:X_LSB];
  assign in_y     = s_axis_tdata[Y_LSB+COORD_W-1:Y_LSB];

  // Pipeline advance: all stages move unless a result is held
  logic pipe_en;
  logic accept;
  logic out_valid_q;

  assign pipe_en       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = pipe_en;
  assign accept        = s_axis_tvalid && pipe_en;

  // Table write on a load transaction, into the first-level copy
  logic table_we;
  assign table_we = accept && (s_axis_tuser == OP_LOAD);

  // Second-level copies take the write one stage later, so a point already
  // in flight still reads the old entry and every later point the new one
  logic              ld0_q;
  logic [IDX_W-1:0]  ld_idx0_q;
  logic [HASH_W-1:0] ld_val0_q;
  logic              table_we_late;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld0_q <= 1'b0;
    end else if (pipe_en) begin
      ld0_q <= table_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ld_idx0_q <= in_index;
      ld_val0_q <= in_value;
    end
  end

  assign table_we_late = pipe_en && ld0_q;

  // Stage 0: split coordinates into cell index and fraction
  logic             v0_q;
  logic [IDX_W-1:0] xi0_q;
  logic [IDX_W-1:0] yi0_q;
  logic [F-1:0]     xf0_q;
  logic [F-1:0]     yf0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (pipe_en) begin
      v0_q <= accept && (s_axis_tuser == OP_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      xi0_q <= in_x[F+IDX_W-1:F];
      yi0_q <= in_y[F+IDX_W-1:F];
      xf0_q <= in_x[F-1:0];
      yf0_q <= in_y[F-1:0];
    end
  end

  // First lookup level: P[xi], P[xi + 1]
  logic [HASH_W-1:0] px0;
  logic [HASH_W-1:0] px1;
  logic [IDX_W-1:0]  xi0_inc;

  assign xi0_inc = xi0_q + IDX_W'(1);

  gn2d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_SIZE)) u_ram_x (
    .clk_i     (clk_i),
    .we_i      (table_we),
    .waddr_i   (in_index),
    .wdata_i   (in_value),
    .re_i      (pipe_en),
    .raddr_a_i (xi0_q),
    .raddr_b_i (xi0_inc),
    .rdata_a_o (px0),
    .rdata_b_o (px1)
  );

  // Stage 1 side registers
  logic             v1_q;
  logic [IDX_W-1:0] yi1_q;
  logic [F-1:0]     xf1_q;
  logic [F-1:0]     yf1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      yi1_q <= yi0_q;
      xf1_q <= xf0_q;
      yf1_q <= yf0_q;
    end
  end

  // Second lookup level: the four corner hashes
  logic [IDX_W-1:0]  a_lo;
  logic [IDX_W-1:0]  a_hi;
  logic [IDX_W-1:0]  b_lo;
  logic [IDX_W-1:0]  b_hi;
  logic [HASH_W-1:0] h_aa;
  logic [HASH_W-1:0] h_ab;
  logic [HASH_W-1:0] h_ba;
  logic [HASH_W-1:0] h_bb;

  assign a_lo = px0[IDX_W-1:0] + yi1_q;
  assign a_hi = a_lo + IDX_W'(1);
  assign b_lo = px1[IDX_W-1:0] + yi1_q;
  assign b_hi = b_lo + IDX_W'(1);

  gn2d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_SIZE)) u_ram_a (
    .clk_i     (clk_i),
    .we_i      (table_we_late),
    .waddr_i   (ld_idx0_q),
    .wdata_i   (ld_val0_q),
    .re_i      (pipe_en),
    .raddr_a_i (a_lo),
    .raddr_b_i (a_hi),
    .rdata_a_o (h_aa),
    .rdata_b_o (h_ab)
  );

  gn2d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_SIZE)) u_ram_b (
    .clk_i     (clk_i),
    .we_i      (table_we_late),
    .waddr_i   (ld_idx0_q),
    .wdata_i   (ld_val0_q),
    .re_i      (pipe_en),
    .raddr_a_i (b_lo),
    .raddr_b_i (b_hi),
    .rdata_a_o (h_ba),
    .rdata_b_o (h_bb)
  );

  // Fade curves, aligned with stage 3
  logic [FADE_W-1:0] fade_u;
  logic [FADE_W-1:0] fade_v;

  gn2d_fade u_fade_x (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .t_i    (xf0_q),
    .fade_o (fade_u)
  );

  gn2d_fade u_fade_y (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .t_i    (yf0_q),
    .fade_o (fade_v)
  );

  // Stage 2: corner gradients
  logic                      v2_q;
  logic [F-1:0]              xf2_q;
  logic [F-1:0]              yf2_q;
  logic signed [DELTA_W-1:0] dx0;
  logic signed [DELTA_W-1:0] dx1;
  logic signed [DELTA_W-1:0] dy0;
  logic signed [DELTA_W-1:0] dy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (pipe_en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      xf2_q <= xf1_q;
      yf2_q <= yf1_q;
    end
  end

  assign dx0 = $signed({2'b00, xf2_q});
  assign dy0 = $signed({2'b00, yf2_q});
  assign dx1 = dx0 - D_ONE;
  assign dy1 = dy0 - D_ONE;

  // Stage 3: registered gradients
  logic                     v3_q;
  logic signed [GRAD_W-1:0] g_aa_q;
  logic signed [GRAD_W-1:0] g_ba_q;
  logic signed [GRAD_W-1:0] g_ab_q;
  logic signed [GRAD_W-1:0] g_bb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (pipe_en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      g_aa_q <= grad_dot(h_aa[2:0], dx0, dy0);
      g_ba_q <= grad_dot(h_ba[2:0], dx1, dy0);
      g_ab_q <= grad_dot(h_ab[2:0], dx0, dy1);
      g_bb_q <= grad_dot(h_bb[2:0], dx1, dy1);
    end
  end

  // Stage 3 -> 4: interpolate along x
  logic signed [LERP_W-1:0] aa_ext;
  logic signed [LERP_W-1:0] ab_ext;
  logic signed [LERP_W-1:0] d_lo;
  logic signed [LERP_W-1:0] d_hi;
  logic signed [LP_W-1:0]   p_lo;
  logic signed [LP_W-1:0]   p_hi;
  logic signed [LP_W-1:0]   r_lo;
  logic signed [LP_W-1:0]   r_hi;

  always_comb begin
    aa_ext = LERP_W'(g_aa_q);
    ab_ext = LERP_W'(g_ab_q);
    d_lo   = LERP_W'(g_ba_q) - aa_ext;
    d_hi   = LERP_W'(g_bb_q) - ab_ext;
    p_lo   = $signed({1'b0, fade_u}) * d_lo;
    p_hi   = $signed({1'b0, fade_u}) * d_hi;
    r_lo   = (p_lo + LP_HALF) >>> F;
    r_hi   = (p_hi + LP_HALF) >>> F;
  end

  logic                     v4_q;
  logic signed [LERP_W-1:0] x1_q;
  logic signed [LERP_W-1:0] x2_q;
  logic [FADE_W-1:0]        fv4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (pipe_en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      x1_q  <= aa_ext + r_lo[LERP_W-1:0];
      x2_q  <= ab_ext + r_hi[LERP_W-1:0];
      fv4_q <= fade_v;
    end
  end

  // Stage 4 -> output: interpolate along y and saturate
  logic signed [LERP_W-1:0] d_y;
  logic signed [LP_W-1:0]   p_y;
  logic signed [LP_W-1:0]   r_y;
  logic signed [LERP_W-1:0] mix_y;
  logic signed [OUT_W-1:0]  noise_d;

  always_comb begin
    d_y   = x2_q - x1_q;
    p_y   = $signed({1'b0, fv4_q}) * d_y;
    r_y   = (p_y + LP_HALF) >>> F;
    mix_y = x1_q + r_y[LERP_W-1:0];
    if (mix_y > SAT_HI) begin
      noise_d = OUT_W'(SAT_HI);
    end else if (mix_y < SAT_LO) begin
      noise_d = OUT_W'(SAT_LO);
    end else begin
      noise_d = mix_y[OUT_W-1:0];
    end
  end

  logic [OUT_W-1:0] noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      noise_q <= noise_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_BYTES_W - OUT_W){1'b0}}, noise_q};

endmodule
